### hw/rtl/sed_pkg.sv
package sed_pkg;

  // Character codes used by the escape decoder
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChBel       = 8'h07;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVt        = 8'h0B;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowV      = 8'h76;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  localparam int unsigned AccW = 10;

  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_DEC   = 4'b0100,
    PH_HEX   = 4'b1000
  } sed_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sed_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic       bad;
  } sed_res_t;

endpackage

### hw/rtl/sed_in_stage.sv
module sed_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sed_pkg::sed_item_t item_i,
  input  logic              adv_i,
  output logic              valid_o,
  output sed_pkg::sed_item_t item_o
);
  import sed_pkg::*;

  logic      valid_q;
  sed_item_t item_q;

  assign ready_o = !valid_q || adv_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

### hw/rtl/sed_decode.sv
module sed_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sed_pkg::sed_item_t item_i,
  input  logic              adv_i,
  output logic              has_res_o,
  output sed_pkg::sed_res_t res_o
);
  import sed_pkg::*;

  logic             at_start_q, at_start_d;
  sed_phase_e       phase_q, phase_d;
  logic [1:0]       left_q, left_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic             stop_q, stop_d;

  logic [7:0]       c;
  logic [3:0]       dig;
  logic             dig_ok;
  logic [AccW-1:0]  acc_next;
  logic [1:0]       left_dec;

  assign c = item_i.data;

  // digit value in the base of the current numeric escape
  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    if (c >= ChZero && c <= ChNine) begin
      dig    = 4'(c - ChZero);
      dig_ok = 1'b1;
    end else if (phase_q == PH_HEX && c >= ChLowA && c <= ChLowF) begin
      dig    = 4'(c - ChLowA + 8'd10);
      dig_ok = 1'b1;
    end else if (phase_q == PH_HEX && c >= ChUpA && c <= ChUpF) begin
      dig    = 4'(c - ChUpA + 8'd10);
      dig_ok = 1'b1;
    end
  end

  // times 16 or times 10 by shifts, wrapped to the accumulator width
  always_comb begin
    if (phase_q == PH_HEX) begin
      acc_next = (acc_q << 4) + AccW'(dig);
    end else begin
      acc_next = (acc_q << 3) + (acc_q << 1) + AccW'(dig);
    end
  end

  assign left_dec = left_q - 2'd1;

  always_comb begin
    at_start_d = at_start_q;
    phase_d    = phase_q;
    left_d     = left_q;
    acc_d      = acc_q;
    stop_d     = stop_q;
    has_res_o  = 1'b0;
    res_o      = '0;

    if (item_i.last) begin
      has_res_o  = 1'b1;
      res_o.done = 1'b1;
      res_o.bad  = !at_start_q && (phase_q != PH_PLAIN);
      at_start_d = 1'b1;
      phase_d    = PH_PLAIN;
      left_d     = 2'd0;
      acc_d      = '0;
      stop_d     = 1'b0;
    end else if (at_start_q) begin
      at_start_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_PLAIN: begin
          if (c == ChBackslash) begin
            phase_d = PH_ESC;
          end else begin
            has_res_o   = 1'b1;
            res_o.data  = c;
            res_o.valid = 1'b1;
          end
        end
        PH_ESC: begin
          phase_d     = PH_PLAIN;
          has_res_o   = 1'b1;
          res_o.valid = 1'b1;
          unique case (c)
            ChQuote:     res_o.data = ChQuote;
            ChBackslash: res_o.data = ChBackslash;
            ChLowA:      res_o.data = ChBel;
            ChLowB:      res_o.data = ChBs;
            ChLowF:      res_o.data = ChFf;
            ChLowN:      res_o.data = ChLf;
            ChLowR:      res_o.data = ChCr;
            ChLowT:      res_o.data = ChTab;
            ChLowV:      res_o.data = ChVt;
            default: begin
              has_res_o   = 1'b0;
              res_o.valid = 1'b0;
              if (c == ChLowX) begin
                phase_d = PH_HEX;
                left_d  = 2'd2;
                acc_d   = '0;
                stop_d  = 1'b0;
              end else if (c >= ChZero && c <= ChNine) begin
                phase_d = PH_DEC;
                left_d  = 2'd2;
                acc_d   = AccW'(c - ChZero);
                stop_d  = 1'b0;
              end
            end
          endcase
        end
        PH_DEC, PH_HEX: begin
          if (!stop_q && dig_ok) begin
            acc_d = acc_next;
          end else begin
            stop_d = 1'b1;
          end
          left_d = left_dec;
          if (left_dec == 2'd0) begin
            has_res_o   = 1'b1;
            res_o.valid = 1'b1;
            res_o.data  = acc_d[7:0];
            phase_d     = PH_PLAIN;
            acc_d       = '0;
            stop_d      = 1'b0;
          end
        end
        default: begin
          phase_d = PH_PLAIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      phase_q    <= PH_PLAIN;
      left_q     <= 2'd0;
      acc_q      <= '0;
      stop_q     <= 1'b0;
    end else if (adv_i) begin
      at_start_q <= at_start_d;
      phase_q    <= phase_d;
      left_q     <= left_d;
      acc_q      <= acc_d;
      stop_q     <= stop_d;
    end
  end

endmodule

### hw/rtl/sed_out_stage.sv
module sed_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sed_pkg::sed_res_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output sed_pkg::sed_res_t res_o
);
  import sed_pkg::*;

  logic     valid_q;
  sed_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hw/rtl/string_escape_decoder_top.sv
// Channel   Dir  tdata (low bit up)   tuser (low bit up)            tlast
// s_axis    in   in_byte[7:0]         -                             in_last
// m_axis    out  out_byte[7:0]        out_valid, bad_escape         done_res
//
// One word a cycle sustained while the output does not stall: a word sits in
// the input register, is decoded there and its result lands in the output
// register when the word advances, from where it is shown on m_axis.
// Reset (rst_ni low, asynchronous) empties both registers; the next word is
// taken as the opening quote, unchecked. A stalled output only holds the
// pipeline when the waiting word produces a result; dropped words keep flowing.
module string_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic [1:0] m_axis_tuser,   // [0] out_valid, [1] bad_escape
  output logic       m_axis_tlast
);
  import sed_pkg::*;

  sed_item_t in_item, cur_item;
  logic      cur_valid;
  logic      adv;
  logic      has_res;
  logic      out_free;
  sed_res_t  res, out_res;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // Advance the held word when it drops or the output register can take it
  assign adv = cur_valid && (!has_res || out_free);

  sed_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  sed_decode u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (cur_item),
    .adv_i     (adv),
    .has_res_o (has_res),
    .res_o     (res)
  );

  sed_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && has_res),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res.data;
  assign m_axis_tuser = {out_res.bad, out_res.valid};
  assign m_axis_tlast = out_res.done;

endmodule
